/* sv/mvspg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mvspg_pkg
// Shared types and codes for the multi-voice step pulse generator.
// ----------------------------------------------------------------------------
package mvspg_pkg;

	localparam logic [2:0] MODE_TICK    = 3'd0;
	localparam logic [2:0] MODE_NOTE_ON = 3'd1;
	localparam logic [2:0] MODE_NOTE_OFF= 3'd2;
	localparam logic [2:0] MODE_RESET   = 3'd3;
	localparam logic [2:0] MODE_HALT    = 3'd4;
	localparam logic [2:0] MODE_TRAVEL  = 3'd5;
	localparam logic [2:0] MODE_LOAD    = 3'd6;

	localparam logic [2:0] REG_FIRST_ADDR = 3'd0;
	localparam logic [2:0] REG_ACTIVE     = 3'd1;
	localparam logic [2:0] REG_MAX_POS    = 3'd2;
	localparam logic [2:0] REG_MAX_NOTE   = 3'd3;
	localparam logic [2:0] REG_TICK_INC   = 3'd4;
	localparam logic [2:0] REG_RESET_PER  = 3'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_READ,
		ST_VISIT,
		ST_DONE
	} state_t;

	// one drive record held in the drive memory
	typedef struct packed {
		logic [6:0]  note;
		logic [15:0] period;
		logic [16:0] accum;
		logic [15:0] position;
		logic        direction;
		logic        restricted;
	} drive_t;

endpackage

/* sv/multi_voice_step_pulse_generator_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_voice_step_pulse_generator_core
// Per-drive note, period, accumulator and bouncing position for stepper voices.
// ----------------------------------------------------------------------------
// Every transfer on the input channel (tick, note on/off, reset, halt, set
// travel, table load) gives exactly one result transfer carrying the step and
// direction bits of all active drives, an all-home flag and an accepted flag.
// Drive state lives in a single-port drive memory and note periods in a table
// memory, both with registered reads. An item is handled by a sequencer that
// visits drives 0..DRIVES-1 in turn, each in a read state and then a visit
// state (modify and write back), followed by a done state; a note-on takes
// its period from the table entry for its note. A new item is taken once the
// previous result has left the output register. The table powers up
// undefined; an entry must be loaded before a note-on reads it.
// ----------------------------------------------------------------------------
module multi_voice_step_pulse_generator_core
	import mvspg_pkg::*;
#(
	parameter int DRIVES = 8,
	parameter int NOTES  = 128
) (
	input  logic        clk,
	input  logic        arst_n,
	// input channel
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  mode,
	input  logic [7:0]  drive_address,
	input  logic [6:0]  note,
	input  logic        restrict_travel,
	input  logic [15:0] table_period,
	// result channel
	output logic        out_valid,
	input  logic        out_stall,
	output logic [15:0] step_dir_bits,
	output logic        all_home,
	output logic        accepted,
	// configuration
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int DW = (DRIVES > 1) ? $clog2(DRIVES) : 1;
	localparam int NW = (NOTES > 1) ? $clog2(NOTES) : 1;

	// configuration registers
	logic [7:0]  first_addr_q;
	logic [3:0]  active_q;
	logic [15:0] max_pos_q;
	logic [6:0]  max_note_q;
	logic [15:0] tick_inc_q;
	logic [15:0] reset_per_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_addr_q <= 8'd1;
			active_q     <= 4'd8;
			max_pos_q    <= 16'd158;
			max_note_q   <= 7'd127;
			tick_inc_q   <= 16'd80;
			reset_per_q  <= 16'd8000;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_FIRST_ADDR: first_addr_q <= cfg_data[7:0];
				REG_ACTIVE:     active_q     <= cfg_data[3:0];
				REG_MAX_POS:    max_pos_q    <= cfg_data;
				REG_MAX_NOTE:   max_note_q   <= cfg_data[6:0];
				REG_TICK_INC:   tick_inc_q   <= cfg_data;
				REG_RESET_PER:  reset_per_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// live drive count, clipped to the built number
	logic [5:0] live;
	assign live = ({2'b00, active_q} > 6'(DRIVES)) ? 6'(DRIVES) : {2'b00, active_q};

	// latched item
	logic [2:0]  mode_q;
	logic [7:0]  addr_q;
	logic [6:0]  note_q;
	logic        restr_q;
	logic [15:0] tper_q;

	// decoded target drive
	logic [8:0] rel;
	logic       addr_hit;
	assign rel      = {1'b0, addr_q} - {1'b0, first_addr_q};
	assign addr_hit = (addr_q != 8'd0) && !rel[8] && ({1'b0, rel[7:0]} < {3'b000, live});

	// state memories; the drive memory has a valid bit per entry for reset
	drive_t      drv_mem [DRIVES];
	logic [DRIVES-1:0] drv_vld_q;
	logic [15:0] tbl_mem [NOTES];

	logic        drv_we;
	logic [DW-1:0] drv_addr;
	drive_t      drv_wdata;
	drive_t      drv_raw_q;
	logic        drv_rvld_q;
	drive_t      drv_rd;

	always_ff @(posedge clk) begin
		if (drv_we) drv_mem[drv_addr] <= drv_wdata;
		drv_raw_q <= drv_mem[drv_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			drv_vld_q  <= '0;
			drv_rvld_q <= 1'b0;
		end else begin
			if (drv_we) drv_vld_q[drv_addr] <= 1'b1;
			drv_rvld_q <= drv_vld_q[drv_addr];
		end
	end

	assign drv_rd = drv_rvld_q ? drv_raw_q : '0;

	logic        tbl_we;
	logic [15:0] tbl_q;
	always_ff @(posedge clk) begin
		if (tbl_we) tbl_mem[note_q[NW-1:0]] <= tper_q;
		tbl_q <= tbl_mem[note_q[NW-1:0]];
	end

	// sequencer
	state_t     state_q, state_d;
	logic [5:0] idx_q;
	logic       acc_q, home_q, found_q;
	logic [15:0] bits_q;
	logic       out_valid_q;

	logic last_idx;
	assign last_idx = (idx_q + 6'd1 >= 6'(DRIVES));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (in_valid && !in_stall) state_d = ST_READ;
			ST_READ:  state_d = ST_VISIT;
			ST_VISIT: state_d = last_idx ? ST_DONE : ST_READ;
			ST_DONE:  state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// per-drive modify
	logic        in_live;
	logic        sel;
	drive_t      nd;
	logic        nacc;
	logic [16:0] sum;
	logic [15:0] hi, lo;

	always_comb begin
		in_live = ({1'b0, idx_q} < {1'b0, live});
		sel     = in_live && ((addr_q == 8'd0) || (addr_hit && rel[5:0] == idx_q));
		nd      = drv_rd;
		nacc    = 1'b0;
		sum     = drv_rd.accum + {1'b0, tick_inc_q};
		hi      = drv_rd.restricted ? (max_pos_q >> 1) + 16'd2 : max_pos_q;
		lo      = drv_rd.restricted ? (max_pos_q >> 1) : 16'd0;
		case (mode_q)
			MODE_TICK: if (in_live) begin
				if (drv_rd.period == 16'd0) begin
					nd.accum = '0;
				end else begin
					nd.accum = sum;
					if (sum > {1'b0, drv_rd.period}) begin
						nd.accum = sum - {1'b0, drv_rd.period};
						if (drv_rd.position >= hi) nd.direction = 1'b1;
						else if (drv_rd.position <= lo) nd.direction = 1'b0;
						nd.position = nd.direction ? drv_rd.position - 16'd1
							: drv_rd.position + 16'd1;
					end
					if (drv_rd.note == 7'd0 && nd.position == 16'd0) nd.period = '0;
				end
			end
			MODE_NOTE_ON: if (note_q <= max_note_q) begin
				if ((addr_q == 8'd0) ? (in_live && !found_q && drv_rd.period == 16'd0)
					: sel) begin
					nd.note   = note_q;
					nd.period = ({25'd0, note_q} < NOTES) ? tbl_q : 16'd0;
					nacc      = 1'b1;
				end
			end
			MODE_NOTE_OFF: if (sel && drv_rd.note == note_q) begin
				nd.note = '0; nd.period = '0; nacc = 1'b1;
			end
			MODE_RESET: if (sel) begin
				nd.restricted = 1'b0; nd.note = '0;
				nd.position = max_pos_q; nd.period = reset_per_q; nacc = 1'b1;
			end
			MODE_HALT: if (in_live) begin
				nd.note = '0; nd.period = '0;
			end
			MODE_TRAVEL: if (sel && addr_q != 8'd0) begin
				nd.restricted = restr_q; nacc = 1'b1;
			end
			default: ;
		endcase
	end

	// memory control outputs
	always_comb begin
		drv_addr  = idx_q[DW-1:0];
		drv_we    = (state_q == ST_VISIT);
		drv_wdata = nd;
		tbl_we    = (state_q == ST_DONE) && (mode_q == MODE_LOAD)
			&& ({25'd0, note_q} < NOTES);
	end

	assign in_stall = (state_q != ST_IDLE) || out_valid_q;

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			mode_q  <= mode;
			addr_q  <= drive_address;
			note_q  <= note;
			restr_q <= restrict_travel;
			tper_q  <= table_period;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			idx_q       <= '0;
			acc_q       <= 1'b0;
			home_q      <= 1'b1;
			found_q     <= 1'b0;
			bits_q      <= '0;
			out_valid_q <= 1'b0;
			step_dir_bits <= '0;
			all_home    <= 1'b1;
			accepted    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_valid_q && !out_stall) out_valid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					idx_q   <= '0;
					home_q  <= 1'b1;
					found_q <= 1'b0;
					bits_q  <= '0;
					acc_q   <= (mode == MODE_TICK) || (mode == MODE_HALT)
						|| (mode == MODE_RESET && drive_address == 8'd0);
				end
				ST_VISIT: begin
					idx_q <= idx_q + 6'd1;
					if (nacc) begin
						acc_q <= 1'b1;
						if (mode_q == MODE_NOTE_ON) found_q <= 1'b1;
					end
					if (in_live) begin
						if (nd.position != 16'd0) home_q <= 1'b0;
						if (idx_q < 6'd8)
							bits_q[{idx_q[2:0], 1'b0} +: 2] <= {nd.direction, nd.position[0]};
					end
				end
				ST_DONE: begin
					out_valid_q   <= 1'b1;
					step_dir_bits <= bits_q;
					all_home      <= home_q;
					accepted      <= acc_q || tbl_we;
				end
				default: ;
			endcase
		end
	end

	assign out_valid = out_valid_q;

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE) |=> out_valid)
		else $error("result not raised after sequence");
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> in_stall)
		else $error("input taken while busy");
	a_tick_acc: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DONE && mode_q == MODE_TICK) |=> accepted)
		else $error("tick not accepted");

endmodule

/* verif/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the multi-voice step pulse generator core.
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a bursty driver; every accepted transfer
// is run through a local drive-state predictor whose expected result is
// queued and compared field by field with the result channel. Register
// settings change between phases, only once the core has drained.
// ----------------------------------------------------------------------------
module tb_top
	import mvspg_pkg::*;
;

	localparam int NDRV      = 8;
	localparam int NNOTE     = 128;
	localparam int MODE_NONE = 7;
	localparam int CYCLE_CAP = 1000000;

	typedef struct {
		logic [2:0]  mode;
		logic [7:0]  addr;
		logic [6:0]  note;
		logic        rt;
		logic [15:0] per;
	} request_t;

	typedef struct {
		logic [15:0] bits;
		logic        home;
		logic        acc;
	} drive_status_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = '0;
	logic [7:0]  drive_address = '0;
	logic [6:0]  note = '0;
	logic        restrict_travel = 1'b0;
	logic [15:0] table_period = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] step_dir_bits;
	logic        all_home;
	logic        accepted;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = '0;
	logic [15:0] cfg_data = '0;

	multi_voice_step_pulse_generator_core DUT (.*);

	always #5 clk = ~clk;

	// predictor state
	logic [15:0] note_period [NNOTE];
	logic [6:0]  v_note  [NDRV];
	logic [15:0] v_per   [NDRV];
	logic [16:0] v_acc   [NDRV];
	logic [15:0] v_pos   [NDRV];
	logic        v_dir   [NDRV];
	logic        v_rst   [NDRV];
	int unsigned cf_first = 1, cf_active = 8, cf_maxpos = 158, cf_maxnote = 127;
	int unsigned cf_inc = 80, cf_resetper = 8000;

	request_t      pending_q [$];
	drive_status_t status_q [$];
	bit            loaded_at_gen [NNOTE];
	int            loaded_list [$];
	int            errors = 0;
	int            results_seen = 0;
	int unsigned   cycles = 0;

	function automatic int live_drives();
		return (cf_active > NDRV) ? NDRV : cf_active;
	endfunction

	function automatic int drive_sel(int unsigned a);
		if (a == 0 || a < cf_first) return -1;
		if (a - cf_first >= live_drives()) return -1;
		return int'(a - cf_first);
	endfunction

	task automatic send_home(int d);
		v_rst[d]  = 1'b0;
		v_note[d] = '0;
		v_pos[d]  = cf_maxpos[15:0];
		v_per[d]  = cf_resetper[15:0];
	endtask

	task automatic advance_drive(int d);
		int unsigned hi, lo;
		if (v_per[d] == 0) begin
			v_acc[d] = '0;
			return;
		end
		v_acc[d] = v_acc[d] + cf_inc[16:0];
		if (v_acc[d] > {1'b0, v_per[d]}) begin
			v_acc[d] = v_acc[d] - {1'b0, v_per[d]};
			hi = v_rst[d] ? cf_maxpos / 2 + 2 : cf_maxpos;
			lo = v_rst[d] ? cf_maxpos / 2 : 0;
			if (v_pos[d] >= hi) v_dir[d] = 1'b1;
			else if (v_pos[d] <= lo) v_dir[d] = 1'b0;
			v_pos[d] = v_dir[d] ? v_pos[d] - 16'd1 : v_pos[d] + 16'd1;
		end
		if (v_note[d] == 0 && v_pos[d] == 0) v_per[d] = '0;
	endtask

	// apply one accepted request to the predictor and queue its status
	task automatic predict_status(request_t r);
		int n, d, i;
		drive_status_t s;
		n = live_drives();
		d = drive_sel(r.addr);
		s.bits = '0;
		s.home = 1'b1;
		s.acc  = 1'b0;
		case (int'(r.mode))
			MODE_TICK: begin
				for (i = 0; i < n; i++) advance_drive(i);
				s.acc = 1'b1;
			end
			MODE_NOTE_ON: begin
				if (r.note <= cf_maxnote) begin
					if (r.addr == 0) begin
						d = -1;
						for (i = 0; i < n; i++)
							if (v_per[i] == 0 && d < 0) d = i;
					end
					if (d >= 0) begin
						v_note[d] = r.note;
						v_per[d]  = note_period[r.note];
						s.acc = 1'b1;
					end
				end
			end
			MODE_NOTE_OFF: begin
				for (i = 0; i < n; i++)
					if ((r.addr == 0 || i == d) && v_note[i] == r.note) begin
						v_note[i] = '0;
						v_per[i]  = '0;
						s.acc = 1'b1;
					end
			end
			MODE_RESET: begin
				if (r.addr == 0) begin
					for (i = 0; i < n; i++) send_home(i);
					s.acc = 1'b1;
				end else if (d >= 0) begin
					send_home(d);
					s.acc = 1'b1;
				end
			end
			MODE_HALT: begin
				for (i = 0; i < n; i++) begin
					v_per[i]  = '0;
					v_note[i] = '0;
				end
				s.acc = 1'b1;
			end
			MODE_TRAVEL: begin
				if (d >= 0) begin
					v_rst[d] = r.rt;
					s.acc = 1'b1;
				end
			end
			MODE_LOAD: begin
				note_period[r.note] = r.per;
				s.acc = 1'b1;
			end
			default: ;
		endcase
		for (i = 0; i < n; i++) begin
			if (v_pos[i] != 0) s.home = 1'b0;
			s.bits[2*i]   = v_pos[i][0];
			s.bits[2*i+1] = v_dir[i];
		end
		status_q.push_back(s);
	endtask

	// ---------------- driver: bursts and gaps ----------------
	request_t cur_req;
	int       burst_left = 0, gap_left = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			burst_left = 0;
			gap_left = 0;
		end else begin
			if (in_valid && !in_stall) predict_status(cur_req);
			if (!in_valid || !in_stall) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_q.size() > 0) begin
					cur_req = pending_q.pop_front();
					mode <= cur_req.mode;
					drive_address <= cur_req.addr;
					note <= cur_req.note;
					restrict_travel <= cur_req.rt;
					table_period <= cur_req.per;
					in_valid <= 1'b1;
					burst_left--;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- receiver: stall pattern and checks ----------------
	int  stall_style = 0, style_left = 0, long_left = 0;
	bit  long_done = 1'b0;

	always @(posedge clk or negedge arst_n) begin
		drive_status_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				results_seen++;
				if (status_q.size() == 0) begin
					errors++;
					$display("%0t: result transfer expected none actual bits=%h home=%b acc=%b",
						$time, step_dir_bits, all_home, accepted);
				end else begin
					e = status_q.pop_front();
					if (step_dir_bits !== e.bits) begin
						errors++;
						$display("%0t: step_dir_bits expected %h actual %h",
							$time, e.bits, step_dir_bits);
					end
					if (all_home !== e.home) begin
						errors++;
						$display("%0t: all_home expected %b actual %b", $time, e.home, all_home);
					end
					if (accepted !== e.acc) begin
						errors++;
						$display("%0t: accepted expected %b actual %b", $time, e.acc, accepted);
					end
				end
			end
			// one long hold-off mid-run so the core backs up into its input
			if (!long_done && results_seen == 400) begin
				long_done = 1'b1;
				long_left = 600;
			end
			if (style_left == 0) begin
				style_left = $urandom_range(20, 80);
				stall_style = $urandom_range(0, 2);
			end
			style_left--;
			if (long_left > 0) begin
				long_left--;
				out_stall <= 1'b1;
			end else case (stall_style)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 9) < 3);
				default: out_stall <= ($urandom_range(0, 9) < 7);
			endcase
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_CAP) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	// ---------------- stimulus ----------------
	function automatic request_t mk(int m, int a, int n, int rt, int p);
		request_t r;
		r.mode = m[2:0];
		r.addr = a[7:0];
		r.note = n[6:0];
		r.rt   = rt[0];
		r.per  = p[15:0];
		return r;
	endfunction

	task automatic queue_req(request_t r);
		if (r.mode == MODE_LOAD && !loaded_at_gen[r.note]) begin
			loaded_at_gen[r.note] = 1'b1;
			loaded_list.push_back(r.note);
		end
		pending_q.push_back(r);
	endtask

	function automatic int pick_addr();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) return 0;
		if (r == 1) return $urandom_range(0, 255);
		return (cf_first + $urandom_range(0, live_drives())) & 8'hFF;
	endfunction

	function automatic int pick_period();
		case ($urandom_range(0, 5))
			0: return $urandom_range(0, 65535);
			1: return 0;
			2: return $urandom_range(1, 60);
			default: return $urandom_range(40, 1500);
		endcase
	endfunction

	task automatic queue_random(int count);
		int k, r, nt;
		for (k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45) queue_req(mk(MODE_TICK, pick_addr(), $urandom_range(0, 127),
					$urandom_range(0, 1), $urandom_range(0, 65535)));
			else if (r < 62) begin
				// note-on only ever names an entry that has been loaded
				nt = loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				queue_req(mk(MODE_NOTE_ON, pick_addr(), nt, $urandom_range(0, 1),
					$urandom_range(0, 65535)));
			end else if (r < 72) begin
				nt = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
					: loaded_list[$urandom_range(0, loaded_list.size() - 1)];
				queue_req(mk(MODE_NOTE_OFF, pick_addr(), nt, 0, 0));
			end else if (r < 76) queue_req(mk(MODE_RESET, pick_addr(), 0, 0, 0));
			else if (r < 78) queue_req(mk(MODE_HALT, pick_addr(), 0, 0, 0));
			else if (r < 86) queue_req(mk(MODE_TRAVEL, pick_addr(), 0,
					$urandom_range(0, 1), 0));
			else if (r < 97) queue_req(mk(MODE_LOAD, pick_addr(), $urandom_range(0, 127),
					0, pick_period()));
			else queue_req(mk(MODE_NONE, pick_addr(), $urandom_range(0, 127),
					$urandom_range(0, 1), $urandom_range(0, 65535)));
		end
	endtask

	task automatic wait_drained();
		while (pending_q.size() != 0 || status_q.size() != 0 || in_valid)
			@(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, int unsigned val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val[15:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_FIRST_ADDR: cf_first    = val & 8'hFF;
			REG_ACTIVE:     cf_active   = val & 4'hF;
			REG_MAX_POS:    cf_maxpos   = val & 16'hFFFF;
			REG_MAX_NOTE:   cf_maxnote  = val & 7'h7F;
			REG_TICK_INC:   cf_inc      = val & 16'hFFFF;
			default:        cf_resetper = val & 16'hFFFF;
		endcase
	endtask

	task automatic set_regs(int f, int a, int mp, int mn, int inc, int rp);
		write_reg(REG_FIRST_ADDR, f);
		write_reg(REG_ACTIVE, a);
		write_reg(REG_MAX_POS, mp);
		write_reg(REG_MAX_NOTE, mn);
		write_reg(REG_TICK_INC, inc);
		write_reg(REG_RESET_PER, rp);
	endtask

	initial begin
		int i;
		for (i = 0; i < NDRV; i++) begin
			v_note[i] = '0; v_per[i] = '0; v_acc[i] = '0;
			v_pos[i] = '0; v_dir[i] = 1'b0; v_rst[i] = 1'b0;
		end
		for (i = 0; i < NNOTE; i++) begin
			note_period[i] = '0;
			loaded_at_gen[i] = 1'b0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// directed: defaults, table extremes, free-drive search, addressing limits
		queue_req(mk(MODE_LOAD, 0, 0, 0, 0));
		queue_req(mk(MODE_LOAD, 255, 127, 1, 65535));
		queue_req(mk(MODE_LOAD, 1, 1, 0, 90));
		queue_req(mk(MODE_LOAD, 0, 64, 0, 37));
		queue_req(mk(MODE_NOTE_ON, 0, 1, 0, 0));
		queue_req(mk(MODE_NOTE_ON, 2, 64, 0, 0));
		queue_req(mk(MODE_NOTE_ON, 0, 0, 0, 0));     // period zero keeps drive free
		queue_req(mk(MODE_NOTE_ON, 9, 1, 0, 0));     // past the active drives
		queue_req(mk(MODE_NOTE_ON, 8, 127, 0, 0));
		for (i = 0; i < 4; i++) queue_req(mk(MODE_TICK, 0, 0, 0, 0));
		queue_req(mk(MODE_TRAVEL, 2, 0, 1, 0));
		queue_req(mk(MODE_TRAVEL, 0, 0, 1, 0));      // address zero is refused
		queue_req(mk(MODE_TICK, 255, 127, 1, 65535));
		queue_req(mk(MODE_NOTE_OFF, 0, 1, 0, 0));
		queue_req(mk(MODE_NOTE_OFF, 4, 0, 0, 0));    // note zero matches idle drive
		queue_req(mk(MODE_RESET, 2, 0, 0, 0));
		queue_req(mk(MODE_RESET, 0, 0, 0, 0));
		queue_req(mk(MODE_TICK, 0, 0, 0, 0));
		queue_req(mk(MODE_HALT, 0, 0, 0, 0));
		queue_req(mk(MODE_NONE, 255, 127, 1, 65535));
		queue_random(300);
		wait_drained();

		set_regs(255, 1, 2, 0, 1, 1);
		queue_random(300);
		wait_drained();
		set_regs(10, 4, 20, 60, 300, 50);
		queue_random(300);
		wait_drained();
		set_regs(1, 8, 65535, 127, 65535, 65535);
		queue_random(300);
		wait_drained();
		set_regs(200, 8, 6, 127, 40, 3);
		queue_random(300);
		wait_drained();
		set_regs(3, 6, 40, 100, 120, 1);
		queue_random(300);
		wait_drained();

		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

/* multi_voice_step_pulse_generator_core.f */
sv/mvspg_pkg.sv
sv/multi_voice_step_pulse_generator_core.sv
verif/tb_top.sv
